// ===== hw/rtl/lfu_table_cache_policy_assert.svh =====
// Assertion macros shared by the tag cache RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef LFU_TABLE_CACHE_POLICY_ASSERT_SVH
`define LFU_TABLE_CACHE_POLICY_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define LFU_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tag cache check failed in the same cycle");

// The property must hold in the cycle after the condition.
`define LFU_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tag cache check failed one cycle later");

`endif

// ===== hw/rtl/lfu_pkg.sv =====
// Types and constants of the LFU tag cache.
// Used by every module of the block; depends on nothing.
package lfu_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEVELS      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TREE_LEAVES = 1 << LEVELS;
   localparam int KEY_W       = 63;
   localparam int CNT_W       = 32;
   localparam int SLOT_OUT_W  = 4;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SLOT_W-1:0] idx_type;

   localparam cnt_type CNT_LIMIT = {CNT_W{1'b1}};
   localparam cnt_type CNT_ONE   = cnt_type'(1);

   typedef struct packed {
      logic    hit;
      idx_type idx;
   } match_type;

endpackage

// ===== hw/rtl/lfu_match.sv =====
// Tag comparators with a priority pick of the lowest matching slot.
// Depends on lfu_pkg.
module lfu_match (
   input  lfu_pkg::key_type   key,
   input  lfu_pkg::key_type   tags [lfu_pkg::SLOTS],
   output lfu_pkg::match_type match
);

   always_comb begin
      match.hit = 1'b0;
      match.idx = '0;
      for (int i = lfu_pkg::SLOTS - 1; i >= 0; i--) begin
         if (tags[i] == key) begin
            match.hit = 1'b1;
            match.idx = lfu_pkg::idx_type'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/lfu_victim.sv =====
// Minimum tree over the use counts; ties go to the lower slot.
// Depends on lfu_pkg.
module lfu_victim (
   input  lfu_pkg::cnt_type counts [lfu_pkg::SLOTS],
   output lfu_pkg::idx_type victim
);

   localparam int NODES = 2 * lfu_pkg::TREE_LEAVES - 1;

   lfu_pkg::cnt_type node_cnt [NODES];
   lfu_pkg::idx_type node_idx [NODES];

   always_comb begin
      for (int i = 0; i < lfu_pkg::TREE_LEAVES; i++) begin
         if (i < lfu_pkg::SLOTS) begin
            node_cnt[lfu_pkg::TREE_LEAVES - 1 + i] = counts[i];
         end else begin
            node_cnt[lfu_pkg::TREE_LEAVES - 1 + i] = lfu_pkg::CNT_LIMIT;
         end
         node_idx[lfu_pkg::TREE_LEAVES - 1 + i] = lfu_pkg::idx_type'(i);
      end
      for (int n = lfu_pkg::TREE_LEAVES - 2; n >= 0; n--) begin
         if (node_cnt[2 * n + 2] < node_cnt[2 * n + 1]) begin
            node_cnt[n] = node_cnt[2 * n + 2];
            node_idx[n] = node_idx[2 * n + 2];
         end else begin
            node_cnt[n] = node_cnt[2 * n + 1];
            node_idx[n] = node_idx[2 * n + 1];
         end
      end
   end

   assign victim = node_idx[0];

endmodule

// ===== hw/rtl/lfu_table_cache_policy.sv =====
// Fully associative LFU tag cache with halving of the use counts.
// Depends on lfu_pkg, lfu_match, lfu_victim and lfu_table_cache_policy_assert.svh.
//
//   channel | direction | ports                          | word
//   req     | in        | req_valid req_stall            | req_action req_key
//   rsp     | out       | rsp_valid rsp_stall            | rsp_hit rsp_slot
//
// A word is registered on entry and its result word is offered from the result register.
// While req_stall is low, one word is taken every cycle; the tag compare, minimum tree
// and count update all settle combinationally between the input and the result register.
// Reset clears all tags and counts at once and empties both registers.
// While a result waits under rsp_stall, one more word is still taken; then
// req_stall rises until the result register drains.
`include "lfu_table_cache_policy_assert.svh"

module lfu_table_cache_policy (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [lfu_pkg::KEY_W-1:0]          req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [lfu_pkg::SLOT_OUT_W-1:0]     rsp_slot
);

   logic               in_valid_ff;
   logic               in_action_ff;
   lfu_pkg::key_type   in_key_ff;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic               rsp_hit_in;
   lfu_pkg::idx_type   rsp_idx_ff;
   lfu_pkg::idx_type   rsp_idx_in;
   lfu_pkg::key_type   tags_ff [lfu_pkg::SLOTS];
   lfu_pkg::key_type   tags_in [lfu_pkg::SLOTS];
   lfu_pkg::cnt_type   cnt_ff  [lfu_pkg::SLOTS];
   lfu_pkg::cnt_type   cnt_in  [lfu_pkg::SLOTS];
   lfu_pkg::match_type match;
   lfu_pkg::idx_type   victim;
   lfu_pkg::cnt_type   inc_cnt;
   logic               advance;
   logic               cnt_sat_any;
   logic               clear_done;
   logic               lookup_done;
   lfu_pkg::key_type   stored_tag;
   logic [lfu_pkg::SLOT_W+lfu_pkg::SLOT_OUT_W-1:0] slot_wide;

   lfu_match u_match (
      .key   (in_key_ff),
      .tags  (tags_ff),
      .match (match)
   );

   lfu_victim u_victim (
      .counts (cnt_ff),
      .victim (victim)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign inc_cnt   = cnt_ff[match.idx] + lfu_pkg::CNT_ONE;

   always_comb begin
      tags_in    = tags_ff;
      cnt_in     = cnt_ff;
      rsp_hit_in = 1'b0;
      rsp_idx_in = '0;
      if (in_action_ff == lfu_pkg::ACT_CLEAR) begin
         for (int i = 0; i < lfu_pkg::SLOTS; i++) begin
            tags_in[i] = '0;
            cnt_in[i]  = '0;
         end
      end else if (match.hit) begin
         rsp_hit_in = 1'b1;
         rsp_idx_in = match.idx;
         if (inc_cnt == lfu_pkg::CNT_LIMIT) begin
            for (int i = 0; i < lfu_pkg::SLOTS; i++) begin
               cnt_in[i] = cnt_ff[i] >> 1;
            end
            cnt_in[match.idx] = inc_cnt >> 1;
         end else begin
            cnt_in[match.idx] = inc_cnt;
         end
      end else begin
         rsp_idx_in      = victim;
         tags_in[victim] = in_key_ff;
         cnt_in[victim]  = lfu_pkg::CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lfu_pkg::SLOTS; i++) begin
            tags_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            tags_ff      <= tags_in;
            cnt_ff       <= cnt_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_key_ff    <= req_key;
      end
      if (advance) begin
         rsp_hit_ff <= rsp_hit_in;
         rsp_idx_ff <= rsp_idx_in;
      end
   end

   assign slot_wide = {{lfu_pkg::SLOT_OUT_W{1'b0}}, rsp_idx_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_slot  = slot_wide[lfu_pkg::SLOT_OUT_W-1:0];

   always_comb begin
      cnt_sat_any = 1'b0;
      for (int i = 0; i < lfu_pkg::SLOTS; i++) begin
         if (cnt_ff[i] == lfu_pkg::CNT_LIMIT) begin
            cnt_sat_any = 1'b1;
         end
      end
   end

   assign clear_done  = advance && (in_action_ff == lfu_pkg::ACT_CLEAR);
   assign lookup_done = advance && (in_action_ff == lfu_pkg::ACT_LOOKUP);
   assign stored_tag  = tags_ff[rsp_idx_ff];

   `LFU_ASSERT_NOW(a_no_saturated_count, clock, reset, 1'b1, !cnt_sat_any)
   `LFU_ASSERT_NEXT(a_clear_result, clock, reset, clear_done, !rsp_hit_ff && rsp_idx_ff == '0)
   `LFU_ASSERT_NEXT(a_lookup_tag_stored, clock, reset, lookup_done, stored_tag == $past(in_key_ff))
   `LFU_ASSERT_NEXT(a_lookup_count_live, clock, reset, lookup_done, cnt_ff[rsp_idx_ff] != '0)
   `LFU_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid_ff)

endmodule
